/* src/dsp_pkg.sv */
// Shared types and constants for the dictionary septet packer.
// Used by dsp_cell, dsp_packer and dictionary_septet_packer_core; no dependencies.
`default_nettype none

package dsp_pkg;

    // Number of character table entries, one per cell of the search chain (2..128)
    localparam int TABLE_DEPTH = 128;

    // Result queue depth at the packer output
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reset value of the table size register
    localparam logic [7:0] TABLE_SIZE_RESET = 8'd128;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef logic [6:0] t_code;
    typedef logic [7:0] t_char;

    // Request as it travels down the cell chain
    typedef struct packed {
        logic  kind;
        t_code idx;
        t_char ch;
        logic  eod;
        logic  hit;
        t_code code;
    } t_token;

    // One packed output byte with its flags
    typedef struct packed {
        t_char pbyte;
        logic  miss;
        logic  last;
    } t_result;

endpackage

`default_nettype wire

/* src/dsp_cell.sv */
// One cell of the search chain: holds one table entry and passes requests on.
// Depends on dsp_pkg.
`default_nettype none

module dsp_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire  dsp_pkg::t_code i_cell_idx,
    input  wire  [7:0]          i_table_size,
    input  wire                 i_valid,
    input  wire  dsp_pkg::t_token i_tok,
    output logic                o_valid,
    output dsp_pkg::t_token     o_tok
);

    logic            r_valid;
    dsp_pkg::t_token r_tok;
    dsp_pkg::t_token n_tok;
    dsp_pkg::t_char  r_entry;

    // Mark the first match among the searched entries
    always_comb begin
        n_tok = i_tok;
        if (i_tok.kind == dsp_pkg::KIND_DATA && !i_tok.hit &&
            ({1'b0, i_cell_idx} < i_table_size) && (r_entry == i_tok.ch)) begin
            n_tok.hit  = 1'b1;
            n_tok.code = i_cell_idx;
        end
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Advance the request payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    // Load the entry when a load request for this position passes
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_tok.kind == dsp_pkg::KIND_LOAD &&
            i_tok.idx == i_cell_idx) begin
            r_entry <= i_tok.ch;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

/* src/dsp_packer.sv */
// Septet packer: turns 7-bit codes into bytes and queues them for the output stream.
// Depends on dsp_pkg.
`default_nettype none

module dsp_packer (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire dsp_pkg::t_token i_tok,
    output logic             o_ready,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [7:0]       o_m_tdata,   // packed_byte
    output logic             o_m_tuser,   // code_missing
    output logic             o_m_tlast    // end_of_stream
);

    logic [2:0]              r_pos;
    dsp_pkg::t_code          r_carry;
    logic                    r_pm;
    dsp_pkg::t_result        r_queue [dsp_pkg::QUEUE_DEPTH];
    logic [dsp_pkg::QUEUE_AW-1:0] r_wp;
    logic [dsp_pkg::QUEUE_AW-1:0] r_rp;
    logic [dsp_pkg::QUEUE_AW:0]   r_count;

    logic                    take;
    logic                    pop;
    logic                    miss;
    logic [2:0]              q;
    logic [7:0]              main_byte;
    logic [7:0]              flush_byte;
    dsp_pkg::t_code          carry_new;
    logic                    pm_new;
    logic                    has_main;
    logic                    has_flush;
    logic [1:0]              n_push;
    dsp_pkg::t_result        res_main;
    dsp_pkg::t_result        res_flush;
    logic [dsp_pkg::QUEUE_AW-1:0] wp_second;

    // Accept only with room for two results
    assign o_ready = (r_count <= (dsp_pkg::QUEUE_AW+1)'(dsp_pkg::QUEUE_DEPTH - 2));
    assign take    = i_valid && o_ready;
    assign pop     = o_m_tvalid && i_m_tready;

    // Build the completed byte and the flush byte
    always_comb begin
        miss       = !i_tok.hit;
        q          = r_pos + 3'd1;
        main_byte  = (8'(r_carry) << r_pos) | 8'(i_tok.code >> (3'd7 - r_pos));
        carry_new  = i_tok.code & (7'h7F >> r_pos);
        pm_new     = (r_pos != 3'd7) ? miss : 1'b0;
        flush_byte = {1'b0, carry_new} << q;
        has_main   = (r_pos != 3'd0);
        has_flush  = i_tok.eod && (q != 3'd0);
        n_push     = {1'b0, has_main} + {1'b0, has_flush};
        res_main   = '{pbyte: main_byte, miss: miss | r_pm,
                       last: i_tok.eod && (r_pos == 3'd7)};
        res_flush  = '{pbyte: flush_byte, miss: pm_new, last: 1'b1};
        wp_second  = r_wp + dsp_pkg::QUEUE_AW'(has_main);
    end

    // Hold the group position and the leftover bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 3'd0;
            r_carry <= '0;
            r_pm    <= 1'b0;
        end else if (take) begin
            if (i_tok.eod) begin
                r_pos   <= 3'd0;
                r_carry <= '0;
                r_pm    <= 1'b0;
            end else begin
                r_pos   <= q;
                r_carry <= carry_new;
                r_pm    <= pm_new;
            end
        end
    end

    // Write up to two results into the queue
    always_ff @(posedge i_clk) begin
        if (take && has_main) begin
            r_queue[r_wp] <= res_main;
        end
        if (take && has_flush) begin
            r_queue[wp_second] <= res_flush;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (take) begin
                r_wp <= r_wp + dsp_pkg::QUEUE_AW'(n_push);
            end
            if (pop) begin
                r_rp <= r_rp + dsp_pkg::QUEUE_AW'(1);
            end
            r_count <= r_count + (take ? (dsp_pkg::QUEUE_AW+1)'(n_push) : '0)
                       - (dsp_pkg::QUEUE_AW+1)'(pop);
        end
    end

    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = r_queue[r_rp].pbyte;
    assign o_m_tuser  = r_queue[r_rp].miss;
    assign o_m_tlast  = r_queue[r_rp].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dsp_pkg::QUEUE_AW+1)'(dsp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_eod_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_tok.eod |=> (r_pos == 3'd0) && (r_carry == '0) && !r_pm)
        else $error("packer not back at group start after end of data");

    a_first_code_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_tok.eod && (r_pos == 3'd0) |=> r_count <= $past(r_count))
        else $error("first code of a group produced a byte");

endmodule

`default_nettype wire

/* src/dictionary_septet_packer_core.sv */
// Top level of the dictionary septet packer: search chain of dsp_cell plus dsp_packer.
// Depends on dsp_pkg, dsp_cell and dsp_packer.
`default_nettype none

// Each request walks a chain of TABLE_DEPTH cells, one cell per cycle while the
// chain advances; every cell holds one table entry, loads it when a load request
// for its position passes and marks the first match for a data character. A new
// request enters every cycle unless the chain stalls, so the block takes one item
// per clock in steady state. The whole chain stalls when a data request waits at
// the tail and the four-entry result queue of the packer has fewer than two free
// slots, which happens only while the output side holds off. Write table_size
// only while no request is in the chain.
module dictionary_septet_packer_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [15:0] i_s_tdata,   // entry_index [6:0], char_value [14:7], zero [15]
    input  wire        i_s_tuser,   // kind
    input  wire        i_s_tlast,   // end_of_data
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // packed_byte
    output logic       o_m_tuser,   // code_missing
    output logic       o_m_tlast,   // end_of_stream
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [7:0]  i_cfg_data   // table_size
);

    logic [7:0]      r_table_size;
    logic            adv;
    logic            pk_ready;
    logic            pk_valid;
    logic            chain_valid [dsp_pkg::TABLE_DEPTH+1];
    dsp_pkg::t_token chain_tok   [dsp_pkg::TABLE_DEPTH+1];

    // Table size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= dsp_pkg::TABLE_SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end

    // Feed the head of the chain
    assign chain_valid[0] = i_s_tvalid;
    assign chain_tok[0]   = '{kind: i_s_tuser, idx: i_s_tdata[6:0], ch: i_s_tdata[14:7],
                              eod: i_s_tlast, hit: 1'b0, code: '0};

    // Drop load requests at the tail; stall only for data waiting on the packer
    assign pk_valid   = chain_valid[dsp_pkg::TABLE_DEPTH] &&
                        (chain_tok[dsp_pkg::TABLE_DEPTH].kind == dsp_pkg::KIND_DATA);
    assign adv        = !pk_valid || pk_ready;
    assign o_s_tready = adv;

    // Search chain
    for (genvar j = 0; j < dsp_pkg::TABLE_DEPTH; j++) begin : g_cell
        dsp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (adv),
            .i_cell_idx   (dsp_pkg::t_code'(j)),
            .i_table_size (r_table_size),
            .i_valid      (chain_valid[j]),
            .i_tok        (chain_tok[j]),
            .o_valid      (chain_valid[j+1]),
            .o_tok        (chain_tok[j+1])
        );
    end

    // Byte packer and result queue
    dsp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (pk_valid),
        .i_tok      (chain_tok[dsp_pkg::TABLE_DEPTH]),
        .o_ready    (pk_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for dictionary_septet_packer_core: drives table loads and characters,
// predicts every packed byte and compares it with the block's output stream.
// Depends on dsp_pkg and the dictionary_septet_packer_core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = dsp_pkg::TABLE_DEPTH + 8;

    typedef struct packed {
        bit       kind;
        bit [6:0] idx;
        bit [7:0] ch;
        bit       eod;
    } t_char_req;

    typedef struct packed {
        bit [7:0] data;
        bit       miss;
        bit       last;
    } t_packed_out;

    logic        i_clk      = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_valid  = 1'b0;
    logic [15:0] req_data   = '0;
    logic        req_kind   = 1'b0;
    logic        req_last   = 1'b0;
    logic        byte_ready = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [7:0]  cfg_size   = '0;
    logic        idle_on    = 1'b1;
    logic        hold_long  = 1'b0;

    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [7:0]  o_m_tdata;
    wire         o_m_tuser;
    wire         o_m_tlast;
    wire         o_cfg_ready;

    // Requests waiting for the driver and bytes waiting for the block
    t_char_req   char_requests[$];
    t_packed_out expected_bytes[$];

    // Packer state as the block should hold it
    bit [7:0] dict [dsp_pkg::TABLE_DEPTH];
    bit [7:0] gen_dict [dsp_pkg::TABLE_DEPTH];
    bit [7:0] search_size = 8'd128;
    bit [2:0] grp_pos     = '0;
    bit [6:0] carry       = '0;
    bit       carry_miss  = 1'b0;

    int errors        = 0;
    int chars_seen    = 0;
    int loads_seen    = 0;
    int bytes_checked = 0;
    int ends_checked  = 0;
    int sizes_used    = 0;

    dictionary_septet_packer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (req_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (req_data),     // entry_index [6:0], char_value [14:7], zero [15]
        .i_s_tuser   (req_kind),     // kind
        .i_s_tlast   (req_last),     // end_of_data
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (byte_ready),
        .o_m_tdata   (o_m_tdata),    // packed_byte
        .o_m_tuser   (o_m_tuser),    // code_missing
        .o_m_tlast   (o_m_tlast),    // end_of_stream
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_size)      // table_size
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Look up one character, pack its code and queue the bytes it completes
    function automatic void predict_request(input bit kind, input bit [6:0] idx,
                                            input bit [7:0] ch, input bit eod);
        int unsigned limit;
        int unsigned j;
        int unsigned mask;
        bit [6:0]    code;
        bit          miss;
        bit [2:0]    pos;
        bit [2:0]    nxt_pos;
        bit [15:0]   wide;
        t_packed_out r;
        if (kind == dsp_pkg::KIND_LOAD) begin
            dict[idx] = ch;
            loads_seen++;
            return;
        end
        chars_seen++;
        limit = (search_size > dsp_pkg::TABLE_DEPTH) ? dsp_pkg::TABLE_DEPTH : search_size;
        code  = '0;
        miss  = 1'b1;
        // first matching entry wins
        for (j = 0; j < limit; j++) begin
            if (miss && dict[j] == ch) begin
                code = j[6:0];
                miss = 1'b0;
            end
        end
        pos = grp_pos;
        if (pos == 3'd0) begin
            carry      = code;
            carry_miss = miss;
        end else begin
            wide   = ({9'b0, carry} << pos) | ({9'b0, code} >> (7 - pos));
            r.data = wide[7:0];
            r.miss = carry_miss | miss;
            r.last = eod && (pos == 3'd7);
            expected_bytes.push_back(r);
            mask       = (32'd1 << (7 - pos)) - 1;
            carry      = code & mask[6:0];
            carry_miss = (pos < 3'd7) ? miss : 1'b0;
        end
        nxt_pos = pos + 3'd1;
        grp_pos = nxt_pos;
        // flush a partial byte, padded with zeros
        if (eod) begin
            if (nxt_pos != 3'd0) begin
                wide   = {9'b0, carry} << nxt_pos;
                r.data = wide[7:0];
                r.miss = carry_miss;
                r.last = 1'b1;
                expected_bytes.push_back(r);
            end
            grp_pos    = '0;
            carry      = '0;
            carry_miss = 1'b0;
        end
    endfunction

    function automatic void report_field(input string field, input int want, input int got);
        errors++;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
    endfunction

    // Request driver: hold each request until accepted, idle in random bursts
    always @(posedge i_clk) begin : drive_requests
        t_char_req nxt;
        int        send_gap;
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_valid && o_s_tready)
                predict_request(req_kind, req_data[6:0], req_data[14:7], req_last);
            if (!req_valid || o_s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    req_valid <= 1'b0;
                end else if (char_requests.size() != 0) begin
                    nxt = char_requests.pop_front();
                    req_valid <= 1'b1;
                    req_kind  <= nxt.kind;
                    req_data  <= {1'b0, nxt.ch, nxt.idx};
                    req_last  <= nxt.eod;
                    if (idle_on && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: check each accepted byte, stall in random bursts
    always @(posedge i_clk) begin : watch_bytes
        t_packed_out want;
        int          stall_left;
        if (!rst_n) begin
            byte_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && byte_ready) begin
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $error("unexpected packed byte 0x%02h with nothing expected", o_m_tdata);
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (want.last)
                        ends_checked++;
                    if (o_m_tdata !== want.data)
                        report_field("packed_byte", want.data, o_m_tdata);
                    if (o_m_tuser !== want.miss)
                        report_field("code_missing", want.miss, o_m_tuser);
                    if (o_m_tlast !== want.last)
                        report_field("end_of_stream", want.last, o_m_tlast);
                end
            end
            if (hold_long) begin
                byte_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                byte_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                byte_ready <= 1'b0;
            end else begin
                byte_ready <= 1'b1;
            end
        end
    end

    // Long output hold-off while the sender keeps offering, to fill the block
    initial begin : long_backpressure
        do @(posedge i_clk); while (chars_seen < 300 || char_requests.size() < 60);
        hold_long <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("dictionary_septet_packer_core test failed");
        $finish;
    end

    function automatic void queue_request(input bit kind, input bit [6:0] idx,
                                          input bit [7:0] ch, input bit eod);
        t_char_req r;
        r.kind = kind;
        r.idx  = idx;
        r.ch   = ch;
        r.eod  = eod;
        if (kind == dsp_pkg::KIND_LOAD)
            gen_dict[idx] = ch;
        char_requests.push_back(r);
    endfunction

    // Mostly characters present in the searched part of the table
    function automatic bit [7:0] pick_char();
        int lim;
        lim = (search_size > dsp_pkg::TABLE_DEPTH) ? dsp_pkg::TABLE_DEPTH : search_size;
        if (lim != 0 && $urandom_range(0, 3) != 0)
            return gen_dict[$urandom_range(0, lim - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Load every entry, either from the full byte range or a tiny alphabet
    task automatic fill_table(input bit few_letters);
        int i;
        for (i = 0; i < dsp_pkg::TABLE_DEPTH; i++)
            queue_request(dsp_pkg::KIND_LOAD, 7'(i),
                          few_letters ? 8'($urandom_range(8'h41, 8'h48))
                                      : 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic queue_random(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                queue_request(dsp_pkg::KIND_LOAD, 7'($urandom_range(0, 127)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                queue_request(dsp_pkg::KIND_DATA, 7'($urandom_range(0, 127)), pick_char(),
                              $urandom_range(0, 9) == 0);
        end
    endtask

    // Wait until every request is in, every byte is out and the chain is empty
    task automatic settle();
        while (char_requests.size() != 0 || req_valid)
            @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_size(input bit [7:0] size);
        settle();
        cfg_valid <= 1'b1;
        cfg_size  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        search_size = size;
        sizes_used++;
    endtask

    initial begin : run_phases
        int i;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two searched entries, both byte extremes
        write_table_size(8'd2);
        queue_request(dsp_pkg::KIND_LOAD, 7'd0, 8'h00, 1'b1);   // end mark on a load is ignored
        queue_request(dsp_pkg::KIND_LOAD, 7'd1, 8'hFF, 1'b0);
        queue_request(dsp_pkg::KIND_LOAD, 7'd127, 8'hA5, 1'b0);
        // full group of eight, end mark on the last code
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h00, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h7E, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h00, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h80, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd127, 8'hFF, 1'b1);
        // partial groups flushed with padding
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h00, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b1);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h5A, 1'b1);
        for (i = 0; i < 7; i++)
            queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, i == 6);

        // Nothing searched: every character misses
        write_table_size(8'd0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'h00, 1'b0);
        queue_request(dsp_pkg::KIND_DATA, 7'd0, 8'hFF, 1'b1);

        // Random phases over several table sizes
        write_table_size(8'd128);
        fill_table(1'b0);
        queue_random(250);

        write_table_size(8'd1);
        queue_random(150);

        write_table_size(8'd255);
        fill_table(1'b1);
        queue_random(200);

        write_table_size(8'($urandom_range(2, 127)));
        queue_random(200);

        write_table_size(8'd0);
        queue_random(60);

        // Last part runs at full rate with no idling
        write_table_size(8'd128);
        idle_on <= 1'b0;
        queue_random(250);

        settle();
        if (expected_bytes.size() != 0) begin
            errors++;
            $error("%0d packed bytes never arrived", expected_bytes.size());
        end
        $display("Encoded %0d characters and %0d table loads under %0d table size settings.",
                 chars_seen, loads_seen, sizes_used);
        $display("Checked %0d packed bytes, %0d of them stream ends; %0d errors.",
                 bytes_checked, ends_checked, errors);
        if (errors == 0)
            $display("dictionary_septet_packer_core test passed");
        else
            $display("dictionary_septet_packer_core test failed");
        $finish;
    end

endmodule
